// ===== rtl/bitmap_block_allocator_unit_defines.svh =====
// Assertion macros for the bitmap block allocator checker
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// clocked assertion, off while reset is low
`define BBA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define BBA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    `BBA_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== rtl/bba_pkg.sv =====
// Shared constants, codes and types of the bitmap block allocator
`default_nettype none

package bba_pkg;

    localparam int TOTAL_BLOCKS    = 64;
    localparam int MAX_FILE_BLOCKS = 8;
    localparam int BLOCK_BYTES     = 64;
    localparam int QUEUE_DEPTH     = 2;

    localparam int LEN_W    = 12;
    localparam int IDX_W    = 6;
    localparam int STATUS_W = 2;
    localparam int BLK_W    = $clog2(TOTAL_BLOCKS);
    localparam int CNT_W    = $clog2(TOTAL_BLOCKS + 1);
    localparam int NEED_W   = $clog2(MAX_FILE_BLOCKS + 1);
    localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_SPACE  = 2'd2
    } status_t;

    typedef enum logic {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_ALLOC
    } back_state_t;

    typedef struct packed {
        logic              release_op;
        logic              too_large;
        logic [NEED_W-1:0] need;
        logic [IDX_W-1:0]  rel_index;
    } work_t;

endpackage

`default_nettype wire

// ===== rtl/bba_front.sv =====
// Front end: accepts input beats and classifies them into work entries
`default_nettype none

module bba_front import bba_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             cmd,
    input  wire logic [LEN_W-1:0] byte_length,
    input  wire logic [IDX_W-1:0] release_index,
    output logic                  push_valid,
    output work_t                 push_work,
    input  wire logic             push_ready
);

    logic              stage_valid_reg;
    logic              stage_valid_next;
    work_t             stage_work_reg;
    logic [LEN_W:0]    need_raw;
    logic [LEN_W:0]    need_fix;
    logic              too_large;
    work_t             work_in;
    logic              take;

    assign need_raw  = (LEN_W+1)'(({1'b0, byte_length} + (LEN_W+1)'(BLOCK_BYTES - 1))
                       / BLOCK_BYTES);
    assign need_fix  = (need_raw == '0) ? (LEN_W+1)'(1) : need_raw;
    assign too_large = int'(need_fix) > MAX_FILE_BLOCKS;

    always_comb
    begin
        work_in.release_op = (cmd == CMD_RELEASE);
        work_in.too_large  = too_large;
        work_in.need       = too_large ? '0 : NEED_W'(need_fix);
        work_in.rel_index  = release_index;
    end

    assign in_ready   = !stage_valid_reg || push_ready;
    assign take       = in_valid && in_ready;
    assign push_valid = stage_valid_reg;
    assign push_work  = stage_work_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_work_reg <= work_in;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bba_queue.sv =====
// Short work queue between the front end and the allocation engine
`default_nettype none

module bba_queue import bba_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_valid,
    output logic       wr_ready,
    input  wire work_t wr_work,
    output logic       rd_valid,
    input  wire logic  rd_ready,
    output work_t      rd_work
);

    work_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               do_wr;
    logic               do_rd;

    assign wr_ready = (int'(count_reg) < QUEUE_DEPTH);
    assign rd_valid = (count_reg != '0);
    assign rd_work  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_work;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bba_back.sv =====
// Allocation engine: free map, free count, first-fit scan and result register
`default_nettype none

module bba_back import bba_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    output logic                     q_ready,
    input  wire work_t               q_work,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic [IDX_W-1:0]         block_index,
    output logic                     last
);

    back_state_t              state_reg;
    back_state_t              state_next;
    logic [TOTAL_BLOCKS-1:0]  used_map_reg;
    logic [TOTAL_BLOCKS-1:0]  used_map_next;
    logic [CNT_W-1:0]         free_cnt_reg;
    logic [CNT_W-1:0]         free_cnt_next;
    logic [NEED_W-1:0]        remain_reg;
    logic [NEED_W-1:0]        remain_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic [IDX_W-1:0]         index_reg;
    logic [IDX_W-1:0]         index_next;
    logic                     last_reg;
    logic                     last_next;
    logic                     can_load;
    logic [BLK_W-1:0]         first_free;
    logic [BLK_W-1:0]         rel_idx;
    logic                     rel_in_range;

    function automatic logic [BLK_W-1:0] lowest_free(input logic [TOTAL_BLOCKS-1:0] map);
        logic [BLK_W-1:0] idx;
        idx = '0;
        for (int i = TOTAL_BLOCKS - 1; i >= 0; i--)
        begin
            if (!map[i])
            begin
                idx = BLK_W'(i);
            end
        end
        return idx;
    endfunction

    assign can_load     = !out_valid_reg || out_ready;
    assign first_free   = lowest_free(used_map_reg);
    assign rel_idx      = BLK_W'(q_work.rel_index);
    assign rel_in_range = int'(q_work.rel_index) < TOTAL_BLOCKS;

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign block_index = index_reg;
    assign last        = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        used_map_next  = used_map_reg;
        free_cnt_next  = free_cnt_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        index_next     = index_reg;
        last_next      = last_reg;
        q_ready        = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && can_load)
                begin
                    q_ready = 1'b1;
                    if (q_work.release_op)
                    begin
                        if (rel_in_range && used_map_reg[rel_idx])
                        begin
                            used_map_next[rel_idx] = 1'b0;
                            free_cnt_next          = free_cnt_reg + 1'b1;
                        end
                        out_valid_next = 1'b1;
                        status_next    = ST_OK;
                        index_next     = '0;
                        last_next      = 1'b1;
                    end
                    else if (q_work.too_large)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_TOO_LARGE;
                        index_next     = '0;
                        last_next      = 1'b1;
                    end
                    else if (int'(free_cnt_reg) < int'(q_work.need))
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_NO_SPACE;
                        index_next     = '0;
                        last_next      = 1'b1;
                    end
                    else
                    begin
                        remain_next = q_work.need;
                        state_next  = BK_ALLOC;
                    end
                end
            end
            BK_ALLOC:
            begin
                if (can_load)
                begin
                    used_map_next[first_free] = 1'b1;
                    free_cnt_next  = free_cnt_reg - 1'b1;
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    index_next     = IDX_W'(first_free);
                    last_next      = (remain_reg == NEED_W'(1));
                    remain_next    = remain_reg - 1'b1;
                    if (remain_reg == NEED_W'(1))
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            used_map_reg  <= '0;
            free_cnt_reg  <= CNT_W'(TOTAL_BLOCKS);
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_map_reg  <= used_map_next;
            free_cnt_reg  <= free_cnt_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        index_reg  <= index_next;
        last_reg   <= last_next;
    end

endmodule

`default_nettype wire

// ===== rtl/bitmap_block_allocator_unit.sv =====
// Top level of the bitmap first-fit block allocator
//
//  channel | valid     | ready     | beat fields
//  --------+-----------+-----------+-------------------------------------
//  input   | in_valid  | in_ready  | cmd, byte_length, release_index
//  output  | out_valid | out_ready | status, block_index, last
//
//  Release and refused allocate: handled in the idle state of the allocation engine, one result.
//  Allocate of n blocks: accepted in the idle state, then one first-fit scan per result.
//  An input beat passes through the front stage, the queue and the engine to its first result.
//  Reset clears the free map to all free; no clearing pass is needed.
//  Output stalls hold the engine; the queue keeps the front accepting until it is full.
`default_nettype none

module bitmap_block_allocator_unit import bba_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                cmd,
    input  wire logic [LEN_W-1:0]    byte_length,
    input  wire logic [IDX_W-1:0]    release_index,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic [IDX_W-1:0]         block_index,
    output logic                     last
);

    logic  push_valid;
    logic  push_ready;
    work_t push_work;
    logic  q_valid;
    logic  q_ready;
    work_t q_work;

    bba_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .byte_length   (byte_length),
        .release_index (release_index),
        .push_valid    (push_valid),
        .push_work     (push_work),
        .push_ready    (push_ready)
    );

    bba_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_work  (push_work),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_work  (q_work)
    );

    bba_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_work      (q_work),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .block_index (block_index),
        .last        (last)
    );

endmodule

`default_nettype wire

// ===== rtl/bba_checker.sv =====
// Port-level checker for the block allocator, bound to the top level
`default_nettype none

`include "bitmap_block_allocator_unit_defines.svh"

module bba_checker import bba_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic [STATUS_W-1:0] status,
    input wire logic [IDX_W-1:0]    block_index,
    input wire logic                last
);

    `BBA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(block_index) && $stable(last), "output beat changed while stalled")

    `BBA_ASSERT_IMPLY(a_refuse_single, out_valid && status != ST_OK, last && block_index == '0, "refused result not a single zero-index beat")

    `BBA_ASSERT(a_alloc_burst, out_valid && out_ready && !last |=> out_valid && status == ST_OK, "allocation burst broken")

    `BBA_ASSERT(a_quiet_after_reset, $rose(rst_n) |-> !out_valid, "output valid right after reset")

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (.*);

`default_nettype wire
